### hdl/bti_pkg.sv
// Bracket tree indexer: shared package.
// Field widths, token and status codes, sequencer phases and default sizes.
// No dependencies.
`default_nettype none

package bti_pkg;

  // Default node capacity of one tree
  localparam int unsigned MAX_NODES_DEF = 1024;

  // Fixed result field widths
  localparam int unsigned ID_W  = 10;
  localparam int unsigned LB_W  = 11;
  localparam int unsigned SZ_W  = 11;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned ST_W  = 2;

  // Token kinds
  localparam logic FUNC_OPEN  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_ROOT      = 2'd1;
  localparam logic [ST_W-1:0] ST_MALFORMED = 2'd2;

  // Sequencer phases: RUN takes tokens, FOLD merges a closed node into its parent, if any, and loads its result
  typedef enum logic {
    PH_RUN  = 1'b0,
    PH_FOLD = 1'b1
  } phase_t;

endpackage : bti_pkg

`default_nettype wire

### hdl/bracket_tree_indexer_top.sv
// Bracket tree indexer: top level.
// Stack of per-node accumulators in one bti_ram, top of stack held in registers.
// Depends on bti_pkg and bti_ram.
//
//   Channel  Dir  Handshake           Beat contents
//   in_      in   in_valid/in_stall   func (open/close), label
//   out_     out  out_valid/out_stall one result per token: ids, sizes, forests, status
//
// An open token, and any malformed token, is handled in the run phase; its result is
// registered the cycle after acceptance. For a close token the entry below the top of
// stack is read from the stack RAM (registered read) and the closed node is folded
// into it in the fold phase, during which in_stall is high.
// Reset is synchronous, active low, and clears the counters and handshake state only;
// the stack RAM is not cleared and needs no clearing pass.
// In RUN a beat is taken while the output register is empty or drained that cycle.
`default_nettype none

module bracket_tree_indexer_top #(
  parameter int unsigned MAX_NODES = bti_pkg::MAX_NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // token channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [7:0]                       in_label,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_is_close,
  output logic        [bti_pkg::ID_W-1:0]       out_node_id,
  output logic signed [bti_pkg::LB_W-1:0]       out_leaf_before,
  output logic        [bti_pkg::ID_W-1:0]       out_post_id,
  output logic        [bti_pkg::SZ_W-1:0]       out_subtree_size,
  output logic        [bti_pkg::SUM_W-1:0]      out_size_sum,
  output logic        [bti_pkg::SUM_W-1:0]      out_left_forests,
  output logic        [bti_pkg::SUM_W-1:0]      out_right_forests,
  output logic        [bti_pkg::SUM_W-1:0]      out_special_forests,
  output logic        [bti_pkg::ID_W-1:0]       out_first_leaf,
  output logic        [bti_pkg::ID_W-1:0]       out_last_leaf,
  output logic        [bti_pkg::ST_W-1:0]       out_status
);

  // Node ids and stack addresses; counts that can reach MAX_NODES
  localparam int unsigned IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned SUM_W = bti_pkg::SUM_W;
  localparam int unsigned PW    = 2 * NW + 1;

  localparam logic [NW-1:0] N_ONE = NW'(1);
  localparam logic [NW-1:0] N_TWO = NW'(2);
  localparam logic [NW-1:0] N_CAP = NW'(MAX_NODES);
  localparam logic [NW:0]   N_THREE = (NW + 1)'(3);

  // One stack entry
  typedef struct packed {
    logic [IW-1:0]    node_id;
    logic [NW-1:0]    size;     // own node plus finished children
    logic [SUM_W-1:0] sum;      // size sums of finished children
    logic [SUM_W-1:0] lf;
    logic [SUM_W-1:0] rf;
    logic             fvalid;
    logic [NW-1:0]    fsize;
    logic [IW-1:0]    fleaf;
    logic [NW-1:0]    lsize;
    logic [IW-1:0]    lleaf;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  bti_pkg::phase_t state_r, state_nxt;

  logic [NW-1:0] depth_r, depth_nxt;
  logic [NW-1:0] pre_r, pre_nxt;
  logic [NW-1:0] post_r, post_nxt;
  logic          leaf_vld_r, leaf_vld_nxt;
  logic [IW-1:0] leaf_id_r, leaf_id_nxt;

  entry_t tos_r, tos_nxt;
  entry_t ram_rd;
  entry_t fresh;
  entry_t folded;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;

  logic out_free;
  logic acc;
  logic open_ok, open_err, close_ok, close_err;
  logic load_now, load_fold;

  // close-side values of the popped node
  logic [NW-1:0]    cl_size;
  logic [NW:0]      cl_size3;
  logic [PW-1:0]    cl_prod;
  logic [SUM_W-1:0] cl_sum, cl_lf, cl_rf, cl_half;
  logic [NW-1:0]    cl_fsize, cl_lsize;
  logic [IW-1:0]    cl_fleaf, cl_lleaf;

  // closed node held across the fold cycle
  logic [IW-1:0]    cs_node_id_r;
  logic [NW-1:0]    cs_post_r;
  logic [NW-1:0]    cs_size_r;
  logic [SUM_W-1:0] cs_sum_r, cs_lf_r, cs_rf_r, cs_half_r;
  logic [IW-1:0]    cs_fleaf_r, cs_lleaf_r;
  logic             cs_has_parent_r;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_is_close_r;
  logic [bti_pkg::ID_W-1:0] out_node_id_r, out_post_id_r, out_first_leaf_r, out_last_leaf_r;
  logic [bti_pkg::LB_W-1:0] out_leaf_before_r;
  logic [bti_pkg::SZ_W-1:0] out_subtree_size_r;
  logic [SUM_W-1:0]         out_size_sum_r, out_left_forests_r, out_right_forests_r;
  logic [SUM_W-1:0]         out_special_forests_r;
  logic [bti_pkg::ST_W-1:0] out_status_r;

  // ---------------------------------------------------------------------------
  // Stack RAM: entries below the top of stack
  // ---------------------------------------------------------------------------
  bti_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (tos_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bti_pkg::PH_RUN: begin
        if (close_ok) begin
          state_nxt = bti_pkg::PH_FOLD;
        end
      end
      bti_pkg::PH_FOLD: begin
        state_nxt = bti_pkg::PH_RUN;
      end
      default: begin
        state_nxt = bti_pkg::PH_RUN;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = 1'b1;
    load_fold = 1'b0;
    case (state_r)
      bti_pkg::PH_RUN: begin
        in_stall = !out_free;
      end
      bti_pkg::PH_FOLD: begin
        load_fold = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Classify the accepted beat
  always_comb begin
    acc       = in_valid && !in_stall;
    open_ok   = acc && (in_func == bti_pkg::FUNC_OPEN) &&
                (pre_r < N_CAP) && (depth_r < N_CAP);
    open_err  = acc && (in_func == bti_pkg::FUNC_OPEN) && !open_ok;
    close_ok  = acc && (in_func == bti_pkg::FUNC_CLOSE) && (depth_r != '0);
    close_err = acc && (in_func == bti_pkg::FUNC_CLOSE) && (depth_r == '0);
    load_now  = open_ok || open_err || close_err;
  end

  // ---------------------------------------------------------------------------
  // Stack RAM access: push old top on open, fetch parent on close
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = open_ok && (depth_r != '0);
    ram_waddr = IW'(depth_r - N_ONE);
    ram_raddr = IW'(depth_r - N_TWO);
  end

  // ---------------------------------------------------------------------------
  // Pop: results of the node on top of the stack
  // ---------------------------------------------------------------------------
  always_comb begin
    cl_size  = tos_r.size;
    cl_sum   = tos_r.sum + SUM_W'(cl_size);
    cl_fsize = tos_r.fvalid ? tos_r.fsize : '0;
    cl_lsize = tos_r.fvalid ? tos_r.lsize : '0;
    cl_lf    = tos_r.lf + SUM_W'(cl_size - cl_fsize);
    cl_rf    = tos_r.rf + SUM_W'(cl_size - cl_lsize);
    cl_size3 = {1'b0, cl_size} + N_THREE;
    cl_prod  = PW'(cl_size) * PW'(cl_size3);
    cl_half  = SUM_W'(cl_prod >> 1);
    // a leaf is its own first and last leaf
    if (cl_size == N_ONE) begin
      cl_fleaf = tos_r.node_id;
      cl_lleaf = tos_r.node_id;
    end else begin
      cl_fleaf = tos_r.fleaf;
      cl_lleaf = tos_r.lleaf;
    end
  end

  // ---------------------------------------------------------------------------
  // Push and fold: next top of stack
  // ---------------------------------------------------------------------------
  always_comb begin
    fresh         = '0;
    fresh.node_id = IW'(pre_r);
    fresh.size    = N_ONE;

    // merge the closed child into the parent read back from the RAM
    folded      = ram_rd;
    folded.size = ram_rd.size + cs_size_r;
    folded.sum  = ram_rd.sum + cs_sum_r;
    folded.lf   = ram_rd.lf + cs_lf_r;
    folded.rf   = ram_rd.rf + cs_rf_r;
    if (!ram_rd.fvalid) begin
      folded.fvalid = 1'b1;
      folded.fsize  = cs_size_r;
      folded.fleaf  = cs_fleaf_r;
    end
    folded.lsize = cs_size_r;
    folded.lleaf = cs_lleaf_r;

    tos_nxt = tos_r;
    if (open_ok) begin
      tos_nxt = fresh;
    end else if (load_fold && cs_has_parent_r) begin
      tos_nxt = folded;
    end
  end

  // ---------------------------------------------------------------------------
  // Counters
  // ---------------------------------------------------------------------------
  always_comb begin
    depth_nxt    = depth_r;
    pre_nxt      = pre_r;
    post_nxt     = post_r;
    leaf_vld_nxt = leaf_vld_r;
    leaf_id_nxt  = leaf_id_r;
    if (open_ok) begin
      depth_nxt = depth_r + N_ONE;
      pre_nxt   = pre_r + N_ONE;
    end
    if (close_ok) begin
      depth_nxt = depth_r - N_ONE;
      if (depth_r == N_ONE) begin
        // root closed: start a new tree
        pre_nxt      = '0;
        post_nxt     = '0;
        leaf_vld_nxt = 1'b0;
      end else begin
        post_nxt = post_r + N_ONE;
        if (cl_size == N_ONE) begin
          leaf_vld_nxt = 1'b1;
          leaf_id_nxt  = tos_r.node_id;
        end
      end
    end
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_now || load_fold) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bti_pkg::PH_RUN;
      depth_r     <= '0;
      pre_r       <= '0;
      post_r      <= '0;
      leaf_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      pre_r       <= pre_nxt;
      post_r      <= post_nxt;
      leaf_vld_r  <= leaf_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    leaf_id_r <= leaf_id_nxt;
    tos_r     <= tos_nxt;

    // hold the closed node for the fold cycle
    if (close_ok) begin
      cs_node_id_r    <= tos_r.node_id;
      cs_post_r       <= post_r;
      cs_size_r       <= cl_size;
      cs_sum_r        <= cl_sum;
      cs_lf_r         <= cl_lf;
      cs_rf_r         <= cl_rf;
      cs_half_r       <= cl_half;
      cs_fleaf_r      <= cl_fleaf;
      cs_lleaf_r      <= cl_lleaf;
      cs_has_parent_r <= (depth_r != N_ONE);
    end

    if (load_fold) begin
      // closed node result
      out_is_close_r        <= bti_pkg::FUNC_CLOSE;
      out_node_id_r         <= bti_pkg::ID_W'(cs_node_id_r);
      out_leaf_before_r     <= '0;
      out_post_id_r         <= bti_pkg::ID_W'(cs_post_r);
      out_subtree_size_r    <= bti_pkg::SZ_W'(cs_size_r);
      out_size_sum_r        <= cs_sum_r;
      out_left_forests_r    <= cs_lf_r;
      out_right_forests_r   <= cs_rf_r;
      out_special_forests_r <= cs_half_r - cs_sum_r;
      out_first_leaf_r      <= bti_pkg::ID_W'(cs_fleaf_r);
      out_last_leaf_r       <= bti_pkg::ID_W'(cs_lleaf_r);
      out_status_r          <= cs_has_parent_r ? bti_pkg::ST_OK : bti_pkg::ST_ROOT;
    end else if (open_ok) begin
      // opened node
      out_is_close_r        <= bti_pkg::FUNC_OPEN;
      out_node_id_r         <= bti_pkg::ID_W'(pre_r);
      out_leaf_before_r     <= leaf_vld_r ? bti_pkg::LB_W'(leaf_id_r) : '1;
      out_post_id_r         <= '0;
      out_subtree_size_r    <= '0;
      out_size_sum_r        <= '0;
      out_left_forests_r    <= '0;
      out_right_forests_r   <= '0;
      out_special_forests_r <= '0;
      out_first_leaf_r      <= '0;
      out_last_leaf_r       <= '0;
      out_status_r          <= bti_pkg::ST_OK;
    end else if (load_now) begin
      // malformed token with every other field zero
      out_is_close_r        <= in_func;
      out_node_id_r         <= '0;
      out_leaf_before_r     <= '0;
      out_post_id_r         <= '0;
      out_subtree_size_r    <= '0;
      out_size_sum_r        <= '0;
      out_left_forests_r    <= '0;
      out_right_forests_r   <= '0;
      out_special_forests_r <= '0;
      out_first_leaf_r      <= '0;
      out_last_leaf_r       <= '0;
      out_status_r          <= bti_pkg::ST_MALFORMED;
    end
  end

  // Drive the result ports
  assign out_valid           = out_valid_r;
  assign out_is_close        = out_is_close_r;
  assign out_node_id         = out_node_id_r;
  assign out_leaf_before     = out_leaf_before_r;
  assign out_post_id         = out_post_id_r;
  assign out_subtree_size    = out_subtree_size_r;
  assign out_size_sum        = out_size_sum_r;
  assign out_left_forests    = out_left_forests_r;
  assign out_right_forests   = out_right_forests_r;
  assign out_special_forests = out_special_forests_r;
  assign out_first_leaf      = out_first_leaf_r;
  assign out_last_leaf       = out_last_leaf_r;
  assign out_status          = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the fold cycle always finds the result register empty
  a_fold_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bti_pkg::PH_FOLD) |-> !out_valid_r)
    else $error("fold cycle with result register occupied");

  // the fold cycle delivers the closed node's result
  a_fold_loads : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bti_pkg::PH_FOLD) |=> out_valid_r)
    else $error("close result not loaded after fold");

  // every open or malformed beat leaves a result behind
  a_beat_result : assert property (@(posedge clk) disable iff (!rst_n)
    load_now |=> out_valid_r)
    else $error("accepted beat produced no result");

  // no push while the parent entry is being read back
  a_no_write_in_fold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bti_pkg::PH_FOLD) |-> !ram_we)
    else $error("stack write during fold");

  // the stack never holds more nodes than have been opened
  a_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r <= pre_r) && (pre_r <= N_CAP))
    else $error("stack depth out of range");

endmodule : bracket_tree_indexer_top

`default_nettype wire

### hdl/bti_ram.sv
// Bracket tree indexer: generic simple dual-port RAM.
// One write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module bti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : bti_ram

`default_nettype wire

### verif/bti_checker.sv
`timescale 1ns / 100ps
// Bracket tree indexer checker: watches the token and result channels, tracks the node stack,
// predicts each result beat and compares it field by field. Depends on bti_pkg.

module bti_checker
  import bti_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_func,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_is_close,
  input  logic [ID_W-1:0]        out_node_id,
  input  logic signed [LB_W-1:0] out_leaf_before,
  input  logic [ID_W-1:0]        out_post_id,
  input  logic [SZ_W-1:0]        out_subtree_size,
  input  logic [SUM_W-1:0]       out_size_sum,
  input  logic [SUM_W-1:0]       out_left_forests,
  input  logic [SUM_W-1:0]       out_right_forests,
  input  logic [SUM_W-1:0]       out_special_forests,
  input  logic [ID_W-1:0]        out_first_leaf,
  input  logic [ID_W-1:0]        out_last_leaf,
  input  logic [ST_W-1:0]        out_status,
  output int                     fails,
  output int                     pending
);

  typedef struct packed {
    logic                   is_close;
    logic [ID_W-1:0]        node_id;
    logic signed [LB_W-1:0] leaf_before;
    logic [ID_W-1:0]        post_id;
    logic [SZ_W-1:0]        subtree_size;
    logic [SUM_W-1:0]       size_sum;
    logic [SUM_W-1:0]       left_forests;
    logic [SUM_W-1:0]       right_forests;
    logic [SUM_W-1:0]       special_forests;
    logic [ID_W-1:0]        first_leaf;
    logic [ID_W-1:0]        last_leaf;
    logic [ST_W-1:0]        status;
  } token_result_t;

  // Per open node: its preorder id and the sums gathered from its finished children
  int unsigned node_at       [MAX_NODES];
  int unsigned kid_size      [MAX_NODES];
  int unsigned kid_sum       [MAX_NODES];
  int unsigned kid_lf        [MAX_NODES];
  int unsigned kid_rf        [MAX_NODES];
  bit          has_first     [MAX_NODES];
  int unsigned first_size    [MAX_NODES];
  int unsigned first_leaf_of [MAX_NODES];
  int unsigned last_size     [MAX_NODES];
  int unsigned last_leaf_of  [MAX_NODES];

  int unsigned depth;
  int unsigned pre_next;
  int unsigned post_next;
  int          last_leaf;
  int unsigned results_seen;

  token_result_t due_results[$];

  task automatic report_fault(input string msg);
    if (fails < 40) $display("[%0t] bti_checker: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_fault($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             results_seen, field, got, want));
  endtask

  // Apply one token to the tracked stack and return the result it should produce
  function automatic token_result_t index_token(input logic func);
    token_result_t r;
    int unsigned   t, size, sum, fsz, lsz, lf, rf, sp, fl, ll;
    r = '0;
    if (func == FUNC_OPEN) begin
      if (pre_next >= MAX_NODES || depth >= MAX_NODES) begin
        r.status = ST_MALFORMED;
        return r;
      end
      t = depth;
      node_at[t]   = pre_next;
      kid_size[t]  = 0;
      kid_sum[t]   = 0;
      kid_lf[t]    = 0;
      kid_rf[t]    = 0;
      has_first[t] = 1'b0;
      first_size[t] = 0;
      first_leaf_of[t] = 0;
      last_size[t] = 0;
      last_leaf_of[t] = 0;
      depth = t + 1;
      r.node_id     = pre_next[ID_W-1:0];
      r.leaf_before = last_leaf[LB_W-1:0];
      pre_next++;
      return r;
    end

    r.is_close = 1'b1;
    if (depth == 0) begin
      r.status = ST_MALFORMED;
      return r;
    end
    t    = depth - 1;
    size = kid_size[t] + 1;
    sum  = kid_sum[t] + size;
    fsz  = has_first[t] ? first_size[t] : 0;
    lsz  = has_first[t] ? last_size[t] : 0;
    lf   = kid_lf[t] + (size - fsz);
    rf   = kid_rf[t] + (size - lsz);
    sp   = size * (size + 3) / 2;
    sp   = (sp >= sum) ? sp - sum : 0;
    // a node with no children is its own leftmost and rightmost leaf
    if (size == 1) begin
      last_leaf = node_at[t];
      fl = node_at[t];
      ll = node_at[t];
    end else begin
      fl = first_leaf_of[t];
      ll = last_leaf_of[t];
    end
    r.node_id         = node_at[t][ID_W-1:0];
    r.post_id         = post_next[ID_W-1:0];
    r.subtree_size    = size[SZ_W-1:0];
    r.size_sum        = sum[SUM_W-1:0];
    r.left_forests    = lf[SUM_W-1:0];
    r.right_forests   = rf[SUM_W-1:0];
    r.special_forests = sp[SUM_W-1:0];
    r.first_leaf      = fl[ID_W-1:0];
    r.last_leaf       = ll[ID_W-1:0];
    post_next++;
    depth = t;

    // fold the finished node into its parent, or start a fresh tree after the root
    if (t > 0) begin
      kid_size[t-1] += size;
      kid_sum[t-1]  += sum;
      kid_lf[t-1]   += lf;
      kid_rf[t-1]   += rf;
      if (!has_first[t-1]) begin
        has_first[t-1]     = 1'b1;
        first_size[t-1]    = size;
        first_leaf_of[t-1] = fl;
      end
      last_size[t-1]    = size;
      last_leaf_of[t-1] = ll;
      r.status = ST_OK;
    end else begin
      r.status  = ST_ROOT;
      pre_next  = 0;
      post_next = 0;
      last_leaf = -1;
    end
    return r;
  endfunction

  // Check the result beat first, then queue the prediction for a token beat
  always @(posedge clk) begin : watch
    token_result_t want;
    if (!rst_n) begin
      due_results.delete();
      depth     = 0;
      pre_next  = 0;
      post_next = 0;
      last_leaf = -1;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_fault($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = due_results.pop_front();
          check_field("is_close",        32'(out_is_close),        32'(want.is_close));
          check_field("node_id",         32'(out_node_id),         32'(want.node_id));
          check_field("leaf_before",     32'($unsigned(out_leaf_before)),
                      32'($unsigned(want.leaf_before)));
          check_field("post_id",         32'(out_post_id),         32'(want.post_id));
          check_field("subtree_size",    32'(out_subtree_size),    32'(want.subtree_size));
          check_field("size_sum",        32'(out_size_sum),        32'(want.size_sum));
          check_field("left_forests",    32'(out_left_forests),    32'(want.left_forests));
          check_field("right_forests",   32'(out_right_forests),   32'(want.right_forests));
          check_field("special_forests", 32'(out_special_forests),
                      32'(want.special_forests));
          check_field("first_leaf",      32'(out_first_leaf),      32'(want.first_leaf));
          check_field("last_leaf",       32'(out_last_leaf),       32'(want.last_leaf));
          check_field("status",          32'(out_status),          32'(want.status));
        end
        results_seen++;
      end
      if (in_valid && !in_stall)
        due_results.push_back(index_token(in_func));
    end
    pending = due_results.size();
  end

endmodule

### verif/tb_bracket_tree_indexer_top.sv
`timescale 1ns / 100ps
// Bracket tree indexer testbench top: clock, reset, token stimulus and result back-pressure.
// Depends on bti_pkg, bracket_tree_indexer_top and bti_checker.

module tb_bracket_tree_indexer_top;
  import bti_pkg::*;

  localparam int unsigned NODES        = MAX_NODES_DEF;
  localparam int unsigned RANDOM_BEATS = 1050;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_func;
  logic [7:0]             in_label;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_is_close;
  logic [ID_W-1:0]        out_node_id;
  logic signed [LB_W-1:0] out_leaf_before;
  logic [ID_W-1:0]        out_post_id;
  logic [SZ_W-1:0]        out_subtree_size;
  logic [SUM_W-1:0]       out_size_sum;
  logic [SUM_W-1:0]       out_left_forests;
  logic [SUM_W-1:0]       out_right_forests;
  logic [SUM_W-1:0]       out_special_forests;
  logic [ID_W-1:0]        out_first_leaf;
  logic [ID_W-1:0]        out_last_leaf;
  logic [ST_W-1:0]        out_status;
  int                     fails;
  int                     pending;

  int unsigned in_idle_pct   = 14;
  int unsigned out_idle_pct  = 59;
  int unsigned hold_requests = 0;
  int unsigned beats_sent    = 0;

  bracket_tree_indexer_top #(.MAX_NODES(NODES)) dut (.*);

  bti_checker #(.MAX_NODES(NODES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one token beat after random idle cycles and hold it until taken
  task automatic send_beat(input logic func, input logic [7:0] label);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_label <= label;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One well-formed tree of exactly node_cap nodes with random shape; the root stays open
  // until all nodes exist.
  task automatic send_tree(input int unsigned node_cap, input int unsigned open_pct);
    int unsigned opened, level;
    opened = 0;
    level  = 0;
    do begin
      if (opened < node_cap && (level <= 1 || $urandom_range(99) < open_pct)) begin
        send_beat(FUNC_OPEN, 8'($urandom_range(255)));
        opened++;
        level++;
      end else begin
        send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
        level--;
      end
    end while (level != 0);
  endtask

  // Result side back-pressure: random stalls, or a long hold when one is requested
  initial begin : receiver
    int unsigned hold_left, holds_seen;
    out_stall  = 1'b0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_seen != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_seen++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned start, stage, stage_now;
    bit          hold_done;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_OPEN;
    in_label = 8'h00;
    hold_done = 1'b0;
    stage_now = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // close on an empty stack, a lone root, and an empty-stack close after the root
    send_beat(FUNC_CLOSE, 8'hFF);
    send_beat(FUNC_OPEN,  8'h00);
    send_beat(FUNC_CLOSE, 8'hFF);
    send_beat(FUNC_CLOSE, 8'h00);
    // root whose first child has two leaves and whose last child is a leaf
    send_beat(FUNC_OPEN,  8'hFF);
    send_beat(FUNC_OPEN,  8'h00);
    send_beat(FUNC_OPEN,  8'($urandom_range(255)));
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
    send_beat(FUNC_OPEN,  8'($urandom_range(255)));
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
    send_beat(FUNC_OPEN,  8'($urandom_range(255)));
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
    // three-deep chain
    repeat (3) send_beat(FUNC_OPEN, 8'($urandom_range(255)));
    repeat (3) send_beat(FUNC_CLOSE, 8'($urandom_range(255)));

    // random trees, mostly small, with stray closes on an empty stack between them
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      stage = (beats_sent - start) * 3 / RANDOM_BEATS;
      if (stage != stage_now) begin
        drain_results();
        stage_now    = stage;
        in_idle_pct  = (stage == 1) ? 59 : 0;
        out_idle_pct = (stage == 1) ? 14 : 0;
      end
      if (!hold_done && beats_sent - start > 150) begin
        hold_requests++;
        hold_done = 1'b1;
      end
      if ($urandom_range(99) < 12)
        send_beat(FUNC_CLOSE, 8'($urandom_range(255)));
      else if ($urandom_range(19) == 0)
        send_tree($urandom_range(250, 31), $urandom_range(75, 40));
      else
        send_tree($urandom_range(30, 1), $urandom_range(75, 35));
    end

    // a close on the empty stack after the last tree
    send_beat(FUNC_CLOSE, 8'($urandom_range(255)));

    drain_results();
    repeat (10) @(negedge clk);
    if (fails == 0)
      $display("tb_bracket_tree_indexer_top OK");
    else
      $display("tb_bracket_tree_indexer_top NOT OK");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_bracket_tree_indexer_top NOT OK");
    $finish;
  end

endmodule
